// ===== design/ttag_pkg.sv =====
// Package for the tensor transpose address generator.
// Holds the shared widths, register index codes and the queue entry type.
// No dependencies.
package ttag_pkg;

	// Sizes of the block.
	localparam int NUM_DIMS = 4;
	localparam int MAX_RANK = 4;
	localparam int DIM_BITS = 12;
	localparam int EXT_BITS = DIM_BITS + 1;
	localparam int ADDR_BITS = 32;
	localparam int DATA_BITS = 32;
	localparam int RANK_BITS = 3;
	localparam int AXIS_BITS = 2;
	localparam int PERM_BITS = NUM_DIMS * AXIS_BITS;
	localparam int CFG_INDEX_BITS = 3;
	localparam int CFG_DATA_BITS = EXT_BITS;

	// Depth of the queue between front and back.
	localparam int QUEUE_DEPTH = 4;
	localparam int PTR_BITS = 2;
	localparam int COUNT_BITS = PTR_BITS + 1;

	// Largest extent that a dimension may take.
	localparam logic [EXT_BITS-1:0] EXT_MAX = EXT_BITS'(1 << DIM_BITS);

	// Configuration register indexes.
	localparam logic [CFG_INDEX_BITS-1:0] REG_RANK = 3'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_DIM_0 = 3'd1;
	localparam logic [CFG_INDEX_BITS-1:0] REG_DIM_3 = 3'd4;
	localparam logic [CFG_INDEX_BITS-1:0] REG_PERM = 3'd5;

	// Reset values of the configuration registers.
	localparam logic [RANK_BITS-1:0] RANK_RESET = 3'd1;
	localparam logic [EXT_BITS-1:0] DIM_RESET = 13'd1;
	localparam logic [PERM_BITS-1:0] PERM_RESET = 8'd228;

	// One classified element, output dimensions right-aligned so that slot
	// NUM_DIMS-1 is the innermost output dimension; unused slots hold
	// position zero and extent one.
	typedef struct packed {
		logic [NUM_DIMS-1:0][DIM_BITS-1:0] pos;
		logic [NUM_DIMS-1:0][EXT_BITS-1:0] ext;
		logic [DATA_BITS-1:0] value;
		logic last;
	} entry_t;

endpackage

// ===== design/ttag_front.sv =====
// Front part of the tensor transpose address generator: configuration
// registers, position counters and the permutation of positions and extents.
// Depends on ttag_pkg.
module ttag_front (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_wr_en,
	input  logic [ttag_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [ttag_pkg::CFG_DATA_BITS-1:0] cfg_data,
	input  logic in_valid,
	input  logic [ttag_pkg::DATA_BITS-1:0] element_value,
	input  logic queue_full,
	output logic push,
	output ttag_pkg::entry_t push_entry
);

	logic [ttag_pkg::RANK_BITS-1:0] rank_q;
	logic [ttag_pkg::NUM_DIMS-1:0][ttag_pkg::EXT_BITS-1:0] dim_q;
	logic [ttag_pkg::PERM_BITS-1:0] perm_q;
	logic [ttag_pkg::NUM_DIMS-1:0][ttag_pkg::DIM_BITS-1:0] ctr_q;
	logic [ttag_pkg::NUM_DIMS-1:0][ttag_pkg::DIM_BITS-1:0] ctr_next;

	logic [ttag_pkg::RANK_BITS-1:0] rank_eff;
	logic [ttag_pkg::NUM_DIMS-1:0][ttag_pkg::EXT_BITS-1:0] ext_eff;
	logic [ttag_pkg::NUM_DIMS-1:0][ttag_pkg::DIM_BITS-1:0] pos_in;
	logic last;

	// A beat is taken whenever the queue has room.
	assign push = in_valid && !queue_full;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rank_q <= ttag_pkg::RANK_RESET;
			for (int i = 0; i < ttag_pkg::NUM_DIMS; i++) begin
				dim_q[i] <= ttag_pkg::DIM_RESET;
			end
			perm_q <= ttag_pkg::PERM_RESET;
		end else if (cfg_wr_en) begin
			case (cfg_index) inside
				ttag_pkg::REG_RANK: begin
					rank_q <= cfg_data[ttag_pkg::RANK_BITS-1:0];
				end
				[ttag_pkg::REG_DIM_0:ttag_pkg::REG_DIM_3]: begin
					dim_q[ttag_pkg::AXIS_BITS'(cfg_index - ttag_pkg::REG_DIM_0)] <= cfg_data;
				end
				ttag_pkg::REG_PERM: begin
					perm_q <= cfg_data[ttag_pkg::PERM_BITS-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// Effective rank, extents and positions, with out-of-range values clamped.
	always_comb begin
		if (rank_q == '0) begin
			rank_eff = ttag_pkg::RANK_BITS'(1);
		end else if (rank_q > ttag_pkg::RANK_BITS'(ttag_pkg::MAX_RANK)) begin
			rank_eff = ttag_pkg::RANK_BITS'(ttag_pkg::MAX_RANK);
		end else begin
			rank_eff = rank_q;
		end
		for (int a = 0; a < ttag_pkg::NUM_DIMS; a++) begin
			if (ttag_pkg::RANK_BITS'(a) >= rank_eff) begin
				ext_eff[a] = ttag_pkg::EXT_BITS'(1);
				pos_in[a] = '0;
			end else begin
				if (dim_q[a] == '0) begin
					ext_eff[a] = ttag_pkg::EXT_BITS'(1);
				end else if (dim_q[a] > ttag_pkg::EXT_MAX) begin
					ext_eff[a] = ttag_pkg::EXT_MAX;
				end else begin
					ext_eff[a] = dim_q[a];
				end
				pos_in[a] = ctr_q[a];
			end
		end
	end

	// The final element is reached when every used counter is at its end.
	always_comb begin
		last = 1'b1;
		for (int a = 0; a < ttag_pkg::NUM_DIMS; a++) begin
			if (ttag_pkg::RANK_BITS'(a) < rank_eff &&
				({1'b0, ctr_q[a]} + ttag_pkg::EXT_BITS'(1)) < ext_eff[a]) begin
				last = 1'b0;
			end
		end
	end

	// Counter increment, carrying from the innermost used dimension outward.
	// Only the outermost counter wraps at the counter width.
	always_comb begin
		logic carry;
		logic cin;
		logic [ttag_pkg::EXT_BITS-1:0] sum;
		carry = 1'b0;
		cin = 1'b0;
		sum = '0;
		for (int k = ttag_pkg::NUM_DIMS - 1; k >= 0; k--) begin
			ctr_next[k] = ctr_q[k];
			if (ttag_pkg::RANK_BITS'(k) < rank_eff) begin
				cin = (ttag_pkg::RANK_BITS'(k + 1) == rank_eff) ? 1'b1 : carry;
				sum = {1'b0, ctr_q[k]} + ttag_pkg::EXT_BITS'(cin);
				if (cin && k > 0 && sum >= ext_eff[k]) begin
					ctr_next[k] = '0;
					carry = 1'b1;
				end else begin
					ctr_next[k] = sum[ttag_pkg::DIM_BITS-1:0];
					carry = 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctr_q <= '0;
		end else if (push) begin
			ctr_q <= last ? '0 : ctr_next;
		end
	end

	// Permute positions and extents into right-aligned output slots.
	always_comb begin
		logic [ttag_pkg::RANK_BITS-1:0] slot_sum;
		logic [ttag_pkg::AXIS_BITS-1:0] out_dim;
		logic [ttag_pkg::AXIS_BITS-1:0] src;
		slot_sum = '0;
		out_dim = '0;
		src = '0;
		push_entry.value = element_value;
		push_entry.last = last;
		for (int s = 0; s < ttag_pkg::NUM_DIMS; s++) begin
			slot_sum = ttag_pkg::RANK_BITS'(s) + rank_eff;
			if (slot_sum >= ttag_pkg::RANK_BITS'(ttag_pkg::NUM_DIMS)) begin
				out_dim = ttag_pkg::AXIS_BITS'(slot_sum - ttag_pkg::RANK_BITS'(ttag_pkg::NUM_DIMS));
				src = (rank_eff == ttag_pkg::RANK_BITS'(1)) ? '0 :
					perm_q[out_dim*ttag_pkg::AXIS_BITS +: ttag_pkg::AXIS_BITS];
				push_entry.pos[s] = pos_in[src];
				push_entry.ext[s] = ext_eff[src];
			end else begin
				push_entry.pos[s] = '0;
				push_entry.ext[s] = ttag_pkg::EXT_BITS'(1);
			end
		end
	end

endmodule

// ===== design/ttag_queue.sv =====
// Short queue between the front and back parts of the address generator.
// Holds classified elements in arrival order.
// Depends on ttag_pkg.
module ttag_queue (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  ttag_pkg::entry_t push_entry,
	input  logic pop,
	output ttag_pkg::entry_t head_entry,
	output logic full,
	output logic empty
);

	ttag_pkg::entry_t entries_q [ttag_pkg::QUEUE_DEPTH];
	logic [ttag_pkg::PTR_BITS-1:0] wr_ptr_q;
	logic [ttag_pkg::PTR_BITS-1:0] rd_ptr_q;
	logic [ttag_pkg::COUNT_BITS-1:0] count_q;

	assign full = (count_q == ttag_pkg::COUNT_BITS'(ttag_pkg::QUEUE_DEPTH));
	assign empty = (count_q == '0);
	assign head_entry = entries_q[rd_ptr_q];

	// Storage, written at the tail.
	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_entry;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + ttag_pkg::PTR_BITS'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + ttag_pkg::PTR_BITS'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + ttag_pkg::COUNT_BITS'(1);
			end else if (pop && !push) begin
				count_q <= count_q - ttag_pkg::COUNT_BITS'(1);
			end
		end
	end

endmodule

// ===== design/ttag_back.sv =====
// Back part of the address generator: stride products and the dot product
// of positions and strides in a short pipeline, ending in the output register.
// Depends on ttag_pkg.
module ttag_back (
	input  logic clk,
	input  logic arst_n,
	input  ttag_pkg::entry_t head_entry,
	input  logic queue_empty,
	output logic pop,
	output logic out_valid,
	input  logic out_stall,
	output logic [ttag_pkg::ADDR_BITS-1:0] dest_address,
	output logic [ttag_pkg::DATA_BITS-1:0] moved_value,
	output logic tensor_last
);

	logic advance;

	// Stage 1.
	logic v_s1;
	logic [ttag_pkg::ADDR_BITS-1:0] m23_s1;
	logic [ttag_pkg::ADDR_BITS-1:0] t2_s1;
	logic [ttag_pkg::DIM_BITS-1:0] pos0_s1;
	logic [ttag_pkg::DIM_BITS-1:0] pos1_s1;
	logic [ttag_pkg::DIM_BITS-1:0] pos3_s1;
	logic [ttag_pkg::EXT_BITS-1:0] ext1_s1;
	logic [ttag_pkg::DATA_BITS-1:0] value_s1;
	logic last_s1;

	// Stage 2.
	logic v_s2;
	logic [ttag_pkg::ADDR_BITS-1:0] m123_s2;
	logic [ttag_pkg::ADDR_BITS-1:0] t1_s2;
	logic [ttag_pkg::ADDR_BITS-1:0] acc_s2;
	logic [ttag_pkg::DIM_BITS-1:0] pos0_s2;
	logic [ttag_pkg::DATA_BITS-1:0] value_s2;
	logic last_s2;

	// Stage 3.
	logic v_s3;
	logic [ttag_pkg::ADDR_BITS-1:0] t0_s3;
	logic [ttag_pkg::ADDR_BITS-1:0] acc_s3;
	logic [ttag_pkg::DATA_BITS-1:0] value_s3;
	logic last_s3;

	// Output register.
	logic out_valid_q;
	logic [ttag_pkg::ADDR_BITS-1:0] dest_address_q;
	logic [ttag_pkg::DATA_BITS-1:0] moved_value_q;
	logic tensor_last_q;

	// The whole pipeline moves unless a finished beat waits at the output.
	assign advance = !(out_valid_q && out_stall);
	assign pop = advance && !queue_empty;

	assign out_valid = out_valid_q;
	assign dest_address = dest_address_q;
	assign moved_value = moved_value_q;
	assign tensor_last = tensor_last_q;

	// Valid bits of the stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			v_s1 <= !queue_empty;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			out_valid_q <= v_s3;
		end
	end

	// Stage 1: innermost stride product and the second innermost term.
	always_ff @(posedge clk) begin
		if (advance) begin
			m23_s1 <= ttag_pkg::ADDR_BITS'(head_entry.ext[2]) *
				ttag_pkg::ADDR_BITS'(head_entry.ext[3]);
			t2_s1 <= ttag_pkg::ADDR_BITS'(head_entry.pos[2]) *
				ttag_pkg::ADDR_BITS'(head_entry.ext[3]);
			pos0_s1 <= head_entry.pos[0];
			pos1_s1 <= head_entry.pos[1];
			pos3_s1 <= head_entry.pos[3];
			ext1_s1 <= head_entry.ext[1];
			value_s1 <= head_entry.value;
			last_s1 <= head_entry.last;
		end
	end

	// Stage 2: outer stride product, next term and a partial sum.
	always_ff @(posedge clk) begin
		if (advance) begin
			m123_s2 <= m23_s1 * ttag_pkg::ADDR_BITS'(ext1_s1);
			t1_s2 <= ttag_pkg::ADDR_BITS'(pos1_s1) * m23_s1;
			acc_s2 <= ttag_pkg::ADDR_BITS'(pos3_s1) + t2_s1;
			pos0_s2 <= pos0_s1;
			value_s2 <= value_s1;
			last_s2 <= last_s1;
		end
	end

	// Stage 3: outermost term and a further partial sum.
	always_ff @(posedge clk) begin
		if (advance) begin
			t0_s3 <= ttag_pkg::ADDR_BITS'(pos0_s2) * m123_s2;
			acc_s3 <= acc_s2 + t1_s2;
			value_s3 <= value_s2;
			last_s3 <= last_s2;
		end
	end

	// Final sum into the output register.
	always_ff @(posedge clk) begin
		if (advance) begin
			dest_address_q <= acc_s3 + t0_s3;
			moved_value_q <= value_s3;
			tensor_last_q <= last_s3;
		end
	end

endmodule

// ===== design/tensor_transpose_address_gen.sv =====
// Tensor transpose address generator: one element per clock cycle while
// neither in_stall nor out_stall holds. Elements of a tensor of rank 1 to 4
// enter in row-major input order; each leaves with its flat index in the
// transposed tensor, its value unchanged, and tensor_last on the final
// element, after which the position counters restart at zero. A result
// passes through the queue, stages 1 to 3 and the output register, and a
// four-entry queue lets the input keep flowing while the output stalls,
// until it fills. The user must write configuration through the cfg port
// only while no beat is in flight; the block itself does not enforce this.
// Depends on ttag_pkg, ttag_front, ttag_queue and ttag_back.
module tensor_transpose_address_gen (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_wr_en,
	input  logic [ttag_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [ttag_pkg::CFG_DATA_BITS-1:0] cfg_data,
	input  logic in_valid,
	output logic in_stall,
	input  logic [ttag_pkg::DATA_BITS-1:0] element_value,
	output logic out_valid,
	input  logic out_stall,
	output logic [ttag_pkg::ADDR_BITS-1:0] dest_address,
	output logic [ttag_pkg::DATA_BITS-1:0] moved_value,
	output logic tensor_last
);

	logic push;
	logic pop;
	logic queue_full;
	logic queue_empty;
	ttag_pkg::entry_t push_entry;
	ttag_pkg::entry_t head_entry;

	assign in_stall = queue_full;

	// Counters and permutation.
	ttag_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.element_value (element_value),
		.queue_full    (queue_full),
		.push          (push),
		.push_entry    (push_entry)
	);

	// Decoupling queue.
	ttag_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head_entry (head_entry),
		.full       (queue_full),
		.empty      (queue_empty)
	);

	// Address arithmetic and output register.
	ttag_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head_entry   (head_entry),
		.queue_empty  (queue_empty),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.dest_address (dest_address),
		.moved_value  (moved_value),
		.tensor_last  (tensor_last)
	);

endmodule
